// ===== design/rde_pkg.sv =====
// ----------------------------------------------------------------------------
// rde_pkg: shared definitions for the radix digit emitter
// Widths, character codes, register indexes, sequencer states and helpers
// used by the core and its submodules.
// ----------------------------------------------------------------------------
package rde_pkg;

   // Field widths fixed by the interface.
   localparam int CHAR_W     = 8;
   localparam int VALUE_W    = 64;
   localparam int RADIX_W    = 5;
   localparam int ALPHA_W    = 64;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;

   // Largest base that the alphabet can hold.
   localparam int MAX_RADIX_DEFAULT = 16;

   // Digit store: a 64-bit magnitude gives at most 64 digits.
   localparam int DIGIT_ADDR_W = 6;

   // Index of the highest alphabet character.
   localparam int CHAR_IDX_W = 4;

   // Byte lanes of the magnitude walked by the divider.
   localparam int BYTE_IDX_W = 3;

   // Characters that are never allowed among the characters in use.
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

   // Reset contents of the registers: the alphabet "0123456789", base ten.
   localparam logic [ALPHA_W-1:0] ALPHA_LOW_RESET  = 64'h3736_3534_3332_3130;
   localparam logic [ALPHA_W-1:0] ALPHA_HIGH_RESET = 64'h0000_0000_0000_3938;
   localparam logic [RADIX_W-1:0] RADIX_RESET      = 5'd10;

   // Register indexes (byte address divided by eight).
   localparam logic [1:0] REG_ALPHA_LOW  = 2'd0;
   localparam logic [1:0] REG_ALPHA_HIGH = 2'd1;
   localparam logic [1:0] REG_RADIX      = 2'd2;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   // Index of the highest nonzero byte of a word, zero for a zero word.
   function automatic logic [BYTE_IDX_W-1:0] top_byte(input logic [VALUE_W-1:0] x);
      logic [BYTE_IDX_W-1:0] t;
      t = '0;
      for (int i = 0; i < VALUE_W / 8; i++) begin
         if (x[i*8 +: 8] != 8'd0) begin
            t = BYTE_IDX_W'(i);
         end
      end
      return t;
   endfunction

endpackage

// ===== design/radix_digit_emitter_core.sv =====
// ----------------------------------------------------------------------------
// radix_digit_emitter_core: integer to digit string in a configured base
// Converts a signed 32-bit or 64-bit integer to its digits, most significant
// first, using a configured alphabet of up to sixteen characters.
//
//   Channel   Ports                                   Handshake
//   -------   -------------------------------------   -------------------------
//   request   req_kind, req_value                     start high, busy low
//   result    rsp_character, rsp_minus_before,        rsp_valid, one cycle each
//             rsp_last, rsp_error
//   config    psel, penable, pwrite, paddr, pwdata,   APB, pready always high
//             prdata, pready
//
// An item runs the alphabet check over the characters in use, then for each
// digit one pass over the significant bytes of the running quotient in the
// byte-wide divider, then reads the digit store back. An invalid alphabet
// ends the item at the first failing check with one error beat.
// Reset is synchronous and restores the decimal alphabet. Results cannot be
// stalled; busy stays high until the last beat is driven.
// ----------------------------------------------------------------------------
module radix_digit_emitter_core #(
   parameter int MAX_RADIX = rde_pkg::MAX_RADIX_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_kind,
   input  logic [rde_pkg::VALUE_W-1:0]     req_value,
   // Result
   output logic                            rsp_valid,
   output logic [rde_pkg::CHAR_W-1:0]      rsp_character,
   output logic                            rsp_minus_before,
   output logic                            rsp_last,
   output logic                            rsp_error,
   // Configuration
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rde_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [rde_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [rde_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import rde_pkg::*;

   localparam int DIGIT_W = $clog2(MAX_RADIX);

   // Configuration registers.
   logic [ALPHA_W-1:0] alpha_low_ff, alpha_low_in;
   logic [ALPHA_W-1:0] alpha_high_ff, alpha_high_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;

   // Sequencer and datapath registers.
   state_type             state_ff, state_in;
   logic [CHAR_IDX_W-1:0] idx_ff, idx_in;
   logic                  neg_ff, neg_in;
   logic [VALUE_W-1:0]    mag_ff, mag_in;
   logic [RADIX_W-1:0]    rem_ff, rem_in;
   logic [BYTE_IDX_W-1:0] byte_ff, byte_in;
   logic [DIGIT_ADDR_W-1:0] cnt_ff, cnt_in;
   logic [DIGIT_ADDR_W-1:0] ptr_ff, ptr_in;
   logic                  more_ff, more_in;
   logic                  pend_ff, pend_in;
   logic                  plast_ff, plast_in;
   logic                  first_ff, first_in;

   // Result registers.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_minus_ff, rsp_minus_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_error_ff, rsp_error_in;

   // Datapath signals.
   logic [2*ALPHA_W-1:0] alpha;
   logic                 csr_write;
   logic                 accept;
   logic                 range_bad;
   logic                 char_bad;
   logic                 check_done;
   logic [CHAR_W-1:0]    cur_char;
   logic [7:0]           div_byte;
   logic [7:0]           quot_byte;
   logic [RADIX_W-1:0]   rem_out;
   logic [VALUE_W-1:0]   mag_next;
   logic [VALUE_W-1:0]   mag_start;
   logic                 neg_start;
   logic [31:0]          word32;
   logic                 pass_done;
   logic                 ram_wr_en;
   logic                 ram_rd_en;
   logic [DIGIT_W-1:0]   ram_rd_data;

   assign alpha     = {alpha_high_ff, alpha_low_ff};
   assign csr_write = psel & penable & pwrite & pready;
   assign accept    = start & (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign pready    = 1'b1;

   // Register read-back.
   always_comb begin
      unique case (paddr[4:3])
         REG_ALPHA_LOW:  prdata = alpha_low_ff;
         REG_ALPHA_HIGH: prdata = alpha_high_ff;
         REG_RADIX:      prdata = CSR_DATA_W'(radix_ff);
         default:        prdata = '0;
      endcase
   end

   // Register writes; a write to an unused index is dropped.
   always_comb begin
      alpha_low_in  = alpha_low_ff;
      alpha_high_in = alpha_high_ff;
      radix_in      = radix_ff;
      if (csr_write) begin
         unique case (paddr[4:3])
            REG_ALPHA_LOW:  alpha_low_in  = pwdata;
            REG_ALPHA_HIGH: alpha_high_in = pwdata;
            REG_RADIX:      radix_in      = pwdata[RADIX_W-1:0];
            default: ;
         endcase
      end
   end

   // Magnitude and sign of the incoming number.
   assign word32 = req_value[31:0];
   always_comb begin
      if (req_kind == 1'b0) begin
         neg_start = word32[31];
         mag_start = neg_start ? {32'd0, (~word32) + 32'd1} : {32'd0, word32};
      end else begin
         neg_start = req_value[VALUE_W-1];
         mag_start = neg_start ? ((~req_value) + 64'd1) : req_value;
      end
   end

   // Alphabet check: one character per cycle against every later one in use.
   assign range_bad  = (radix_ff < RADIX_W'(2)) || (radix_ff > RADIX_W'(MAX_RADIX));
   assign cur_char   = alpha[idx_ff*CHAR_W +: CHAR_W];
   assign check_done = ({1'b0, idx_ff} == (radix_ff - RADIX_W'(1)));
   always_comb begin
      char_bad = (cur_char == CHAR_MINUS) || (cur_char == CHAR_PLUS);
      for (int j = 0; j < 2 ** CHAR_IDX_W; j++) begin
         if ((RADIX_W'(j) > {1'b0, idx_ff}) && (RADIX_W'(j) < radix_ff) &&
             (alpha[j*CHAR_W +: CHAR_W] == cur_char)) begin
            char_bad = 1'b1;
         end
      end
   end

   // Shared divider: one byte of the magnitude per cycle, top byte first.
   assign div_byte = mag_ff[byte_ff*8 +: 8];

   rde_div_step u_div_step (
      .rem_in        (rem_ff),
      .dividend_byte (div_byte),
      .radix         (radix_ff),
      .quot_byte     (quot_byte),
      .rem_out       (rem_out)
   );

   always_comb begin
      mag_next = mag_ff;
      mag_next[byte_ff*8 +: 8] = quot_byte;
   end
   assign pass_done = (byte_ff == '0);

   // Digit store: written once per finished pass, read back in reverse.
   assign ram_wr_en = (state_ff == ST_DIVIDE) && pass_done;
   assign ram_rd_en = (state_ff == ST_EMIT) && more_ff;

   rde_digit_ram #(
      .ADDR_W (DIGIT_ADDR_W),
      .DATA_W (DIGIT_W)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cnt_ff),
      .wr_data (rem_out[DIGIT_W-1:0]),
      .rd_en   (ram_rd_en),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_data)
   );

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      byte_in      = byte_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      more_in      = more_ff;
      pend_in      = 1'b0;
      plast_in     = plast_ff;
      first_in     = first_ff;
      rsp_valid_in = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_minus_in = rsp_minus_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_error_in = rsp_error_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in   = neg_start;
               mag_in   = mag_start;
               idx_in   = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (range_bad || char_bad) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = '0;
               rsp_minus_in = 1'b0;
               rsp_last_in  = 1'b1;
               rsp_error_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (check_done) begin
               byte_in  = top_byte(mag_ff);
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIVIDE;
            end else begin
               idx_in = idx_ff + CHAR_IDX_W'(1);
            end
         end
         ST_DIVIDE: begin
            mag_in = mag_next;
            rem_in = rem_out;
            if (!pass_done) begin
               byte_in = byte_ff - BYTE_IDX_W'(1);
            end else if ((mag_next == '0) || (cnt_ff == '1)) begin
               // Last digit stored: read them back from the top one.
               ptr_in   = cnt_ff;
               more_in  = 1'b1;
               first_in = 1'b1;
               state_in = ST_EMIT;
            end else begin
               cnt_in  = cnt_ff + DIGIT_ADDR_W'(1);
               byte_in = top_byte(mag_next);
               rem_in  = '0;
            end
         end
         ST_EMIT: begin
            // Issue a read while digits remain.
            if (more_ff) begin
               pend_in  = 1'b1;
               plast_in = (ptr_ff == '0);
               more_in  = (ptr_ff != '0);
               ptr_in   = ptr_ff - DIGIT_ADDR_W'(1);
            end
            // Drive a beat for the read issued in the previous cycle.
            if (pend_ff) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = alpha[CHAR_IDX_W'(ram_rd_data)*CHAR_W +: CHAR_W];
               rsp_minus_in = neg_ff && first_ff;
               rsp_last_in  = plast_ff;
               rsp_error_in = 1'b0;
               first_in     = 1'b0;
               if (plast_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_low_ff  <= ALPHA_LOW_RESET;
         alpha_high_ff <= ALPHA_HIGH_RESET;
         radix_ff      <= RADIX_RESET;
         state_ff      <= ST_IDLE;
         more_ff       <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         alpha_low_ff  <= alpha_low_in;
         alpha_high_ff <= alpha_high_in;
         radix_ff      <= radix_in;
         state_ff      <= state_in;
         more_ff       <= more_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      rem_ff       <= rem_in;
      byte_ff      <= byte_in;
      cnt_ff       <= cnt_in;
      ptr_ff       <= ptr_in;
      plast_ff     <= plast_in;
      first_ff     <= first_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_minus_ff <= rsp_minus_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_character    = rsp_char_ff;
   assign rsp_minus_before = rsp_minus_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_error        = rsp_error_ff;

endmodule

// ===== design/rde_div_step.sv =====
// ----------------------------------------------------------------------------
// rde_div_step: one byte of long division by the base
// Shifts eight dividend bits through the running remainder, subtracting the
// base where it fits, and returns the quotient byte and the new remainder.
// ----------------------------------------------------------------------------
module rde_div_step (
   input  logic [rde_pkg::RADIX_W-1:0] rem_in,
   input  logic [7:0]                  dividend_byte,
   input  logic [rde_pkg::RADIX_W-1:0] radix,
   output logic [7:0]                  quot_byte,
   output logic [rde_pkg::RADIX_W-1:0] rem_out
);
   import rde_pkg::*;

   // Restoring division, most significant bit first. The remainder stays
   // below the base, so its top bit is clear before each shift.
   always_comb begin
      logic [RADIX_W-1:0] r;
      r = rem_in;
      quot_byte = '0;
      for (int i = 7; i >= 0; i--) begin
         r = {r[RADIX_W-2:0], dividend_byte[i]};
         if (r >= radix) begin
            r = r - radix;
            quot_byte[i] = 1'b1;
         end
      end
      rem_out = r;
   end

endmodule

// ===== design/rde_digit_ram.sv =====
// ----------------------------------------------------------------------------
// rde_digit_ram: digit store
// Simple dual-port memory that holds the digits least significant first
// while they are produced, read back in reverse with registered data.
// ----------------------------------------------------------------------------
module rde_digit_ram #(
   parameter int ADDR_W = rde_pkg::DIGIT_ADDR_W,
   parameter int DATA_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);
   import rde_pkg::*;

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/rde_checker.sv =====
// ----------------------------------------------------------------------------
// rde_checker: port-level checks for the radix digit emitter
// Watches the request, result and busy ports and flags sequencing slips.
// ----------------------------------------------------------------------------
module rde_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_valid,
   input logic [rde_pkg::CHAR_W-1:0] rsp_character,
   input logic                       rsp_minus_before,
   input logic                       rsp_last,
   input logic                       rsp_error
);
   import rde_pkg::*;

   // An accepted request keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but busy did not rise");

   // A beat that is not the last one leaves the block still at work.
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("non-final beat while the block is idle");

   // Busy drops exactly with the final beat of an item.
   a_fall_last: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> (rsp_valid && rsp_last))
      else $error("busy fell without a final beat");

   // An error beat stands alone and carries no character or sign.
   a_error_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |->
         (rsp_last && (rsp_character == '0) && !rsp_minus_before))
      else $error("malformed error beat");

endmodule

bind radix_digit_emitter_core rde_checker u_rde_checker (.*);

// ===== bench/tb_radix_digit_emitter_core.sv =====
// ----------------------------------------------------------------------------
// tb_radix_digit_emitter_core: self-checking bench for the digit emitter
// Drives integers through the request channel under several alphabets and
// bases, writes the registers over the APB port between phases, and checks
// every result beat against a predictor that keeps its own register copy.
// ----------------------------------------------------------------------------
module tb_radix_digit_emitter_core;
   import rde_pkg::*;

   localparam int MAX_RADIX = MAX_RADIX_DEFAULT;

   // Kinds of broken alphabet that the random phases can set up.
   typedef enum int {
      FLAW_NONE,
      FLAW_LOW_RADIX,
      FLAW_HIGH_RADIX,
      FLAW_SIGN_CHAR,
      FLAW_REPEAT
   } alphabet_flaw_type;

   // One result beat as seen on the rsp_ ports.
   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              minus_before;
      logic              is_last;
      logic              is_error;
   } digit_beat_type;

   // Predicts the digit string of each accepted number and checks the beats.
   class digit_scoreboard;
      logic [ALPHA_W-1:0] alpha_low;
      logic [ALPHA_W-1:0] alpha_high;
      logic [RADIX_W-1:0] radix;
      digit_beat_type     expected_digits[$];
      int unsigned        error_count;

      function new();
         alpha_low   = ALPHA_LOW_RESET;
         alpha_high  = ALPHA_HIGH_RESET;
         radix       = RADIX_RESET;
         error_count = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_ALPHA_LOW: begin
               alpha_low = data;
            end
            REG_ALPHA_HIGH: begin
               alpha_high = data;
            end
            REG_RADIX: begin
               radix = data[RADIX_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function logic [CHAR_W-1:0] char_at(int unsigned pos);
         if (pos < 8) begin
            return alpha_low[pos*8 +: 8];
         end
         return alpha_high[(pos-8)*8 +: 8];
      endfunction

      // The base must be in range and the characters in use distinct and free of sign characters.
      function bit alphabet_valid();
         logic [CHAR_W-1:0] c;
         if (radix < 2 || radix > MAX_RADIX) begin
            return 1'b0;
         end
         for (int i = 0; i < radix; i++) begin
            c = char_at(i);
            if (c == CHAR_PLUS || c == CHAR_MINUS) begin
               return 1'b0;
            end
            for (int j = i + 1; j < radix; j++) begin
               if (char_at(j) == c) begin
                  return 1'b0;
               end
            end
         end
         return 1'b1;
      endfunction

      // Converts one accepted number and queues its digit beats.
      function void note_request(logic kind, logic [VALUE_W-1:0] value);
         logic [VALUE_W-1:0] mag;
         logic [3:0]         digits[$];
         bit                 neg;
         int                 n;
         if (!alphabet_valid()) begin
            expected_digits.push_back(digit_beat_type'{8'h00, 1'b0, 1'b1, 1'b1});
            return;
         end
         if (!kind) begin
            neg = value[31];
            mag = neg ? (64'h1_0000_0000 - {32'd0, value[31:0]}) : {32'd0, value[31:0]};
         end else begin
            neg = value[63];
            mag = neg ? (64'd0 - value) : value;
         end
         // Digits come out least significant first; store them reversed.
         n = 0;
         do begin
            digits.push_front(4'(mag % 64'(radix)));
            mag = mag / 64'(radix);
            n++;
         end while (mag != 0 && n < 64);
         for (int k = 0; k < n; k++) begin
            expected_digits.push_back(digit_beat_type'{char_at(digits[k]),
                                                       (k == 0) && neg, k == n - 1, 1'b0});
         end
      endfunction

      function void check_beat(digit_beat_type got);
         digit_beat_type want;
         if (expected_digits.size() == 0) begin
            $error("unexpected result beat: character %02h", got.character);
            error_count++;
            return;
         end
         want = expected_digits.pop_front();
         if (got.character !== want.character) begin
            $error("character: expected %02h, actual %02h", want.character, got.character);
            error_count++;
         end
         if (got.minus_before !== want.minus_before) begin
            $error("minus_before: expected %0b, actual %0b",
                   want.minus_before, got.minus_before);
            error_count++;
         end
         if (got.is_last !== want.is_last) begin
            $error("last: expected %0b, actual %0b", want.is_last, got.is_last);
            error_count++;
         end
         if (got.is_error !== want.is_error) begin
            $error("error: expected %0b, actual %0b", want.is_error, got.is_error);
            error_count++;
         end
      endfunction

      function int unsigned pending();
         return expected_digits.size();
      endfunction

      function void report_leftovers();
         if (expected_digits.size() != 0) begin
            $error("%0d expected result beats never arrived", expected_digits.size());
            error_count++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_kind = 1'b0;
   logic [VALUE_W-1:0]    req_value = '0;
   logic                  rsp_valid;
   logic [CHAR_W-1:0]     rsp_character;
   logic                  rsp_minus_before;
   logic                  rsp_last;
   logic                  rsp_error;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   digit_scoreboard sb = new();

   radix_digit_emitter_core #(
      .MAX_RADIX(MAX_RADIX)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_character   (rsp_character),
      .rsp_minus_before(rsp_minus_before),
      .rsp_last        (rsp_last),
      .rsp_error       (rsp_error),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Worst case is far below this: 64 digits, each dividing all eight bytes.
   initial begin
      #30_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Request beats are taken at the edge where start is high and busy low.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         sb.note_request(req_kind, req_value);
      end
   end

   // Result beats last one cycle each and cannot be stalled.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_beat(digit_beat_type'{rsp_character, rsp_minus_before, rsp_last, rsp_error});
      end
   end

   // Presents one number and holds it until the block takes it.
   task automatic send_item(logic kind, logic [VALUE_W-1:0] value);
      start     <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      do @(posedge clock); while (busy);
   endtask

   // Mostly back to back, sometimes a short pause, rarely a long one.
   task automatic idle_gap();
      int unsigned r;
      int unsigned cycles;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return;
      end
      cycles = (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stops sending until every expected beat is in and the block is idle.
   task automatic wait_for_idle();
      start <= 1'b0;
      forever begin
         @(negedge clock);
         if (sb.pending() == 0 && !busy) break;
      end
      @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle until pready. The bus stays
   // selected afterwards so that writes can follow each other directly.
   task automatic write_csr(logic [1:0] idx, logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_reg(idx, data);
   endtask

   task automatic configure(logic [ALPHA_W-1:0] lo, logic [ALPHA_W-1:0] hi,
                            logic [RADIX_W-1:0] rad);
      wait_for_idle();
      write_csr(REG_ALPHA_LOW, lo);
      write_csr(REG_ALPHA_HIGH, hi);
      write_csr(REG_RADIX, {{(CSR_DATA_W-RADIX_W){1'b0}}, rad});
      // Release the bus after the last access.
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Builds sixteen distinct non-sign characters, then breaks them if asked or may put a minus past the base.
   task automatic random_alphabet(input alphabet_flaw_type flaw, input int unsigned rad_pick,
                                  output logic [ALPHA_W-1:0] lo,
                                  output logic [ALPHA_W-1:0] hi,
                                  output logic [RADIX_W-1:0] rad);
      logic [CHAR_W-1:0] chars[16];
      bit [255:0]        used;
      logic [CHAR_W-1:0] c;
      int unsigned       i;
      int unsigned       j;
      used = '0;
      for (int k = 0; k < 16; k++) begin
         do c = CHAR_W'($urandom_range(0, 255));
         while (used[c] || c == CHAR_PLUS || c == CHAR_MINUS);
         used[c]  = 1'b1;
         chars[k] = c;
      end
      rad = (rad_pick != 0) ? RADIX_W'(rad_pick) : RADIX_W'($urandom_range(2, MAX_RADIX));
      case (flaw)
         FLAW_LOW_RADIX: begin
            rad = RADIX_W'($urandom_range(0, 1));
         end
         FLAW_HIGH_RADIX: begin
            rad = RADIX_W'($urandom_range(MAX_RADIX + 1, 31));
         end
         FLAW_SIGN_CHAR: begin
            chars[$urandom_range(0, rad - 1)] = $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
         end
         FLAW_REPEAT: begin
            i = $urandom_range(0, rad - 2);
            j = $urandom_range(i + 1, rad - 1);
            chars[j] = chars[i];
         end
         default: begin
            // A sign character past the base is out of use and harmless.
            if (rad < 16 && $urandom_range(0, 2) == 0) begin
               chars[$urandom_range(rad, 15)] = CHAR_MINUS;
            end
         end
      endcase
      for (int k = 0; k < 8; k++) begin
         lo[k*8 +: 8] = chars[k];
         hi[k*8 +: 8] = chars[k + 8];
      end
   endtask

   // Spreads numbers over small, negative, extreme and full-width values.
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return VALUE_W'($urandom_range(0, 40));
         1: return 64'd0 - VALUE_W'($urandom_range(1, 40));
         2: return {32'($urandom), 32'h8000_0000};
         3: begin
            case ($urandom_range(0, 2))
               0: return 64'h8000_0000_0000_0000;
               1: return 64'h7FFF_FFFF_FFFF_FFFF;
               default: return 64'hFFFF_FFFF_FFFF_FFFF;
            endcase
         end
         default: return {32'($urandom), 32'($urandom)};
      endcase
   endfunction

   localparam logic [ALPHA_W-1:0] HEX_LOW  = 64'h3736_3534_3332_3130;
   localparam logic [ALPHA_W-1:0] HEX_HIGH = 64'h4645_4443_4241_3938;

   initial begin
      logic [ALPHA_W-1:0] lo;
      logic [ALPHA_W-1:0] hi;
      logic [RADIX_W-1:0] rad;
      alphabet_flaw_type  flaw;
      bit                 no_gaps;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Decimal alphabet from reset: zero, signs, and both minimum values.
      send_item(1'b0, 64'd0);
      send_item(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(1'b0, 64'h0000_0000_8000_0000);
      send_item(1'b0, 64'hDEAD_BEEF_7FFF_FFFF);
      send_item(1'b1, 64'd0);
      send_item(1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
      send_item(1'b1, 64'h8000_0000_0000_0000);
      send_item(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);

      // Full sixteen-character alphabet.
      configure(HEX_LOW, HEX_HIGH, 5'd16);
      send_item(1'b1, 64'h0123_4567_89AB_CDEF);
      send_item(1'b0, 64'hFFFF_FFFF_0000_0000);
      send_item(1'b1, 64'hFEDC_BA98_7654_3210);

      // Base two with the extreme characters 00 and FF; signs sit unused.
      configure(64'h2D2B_0000_0000_FF00, 64'd0, 5'd2);
      send_item(1'b1, 64'h8000_0000_0000_0000);
      send_item(1'b0, 64'h0000_0000_8000_0000);
      send_item(1'b1, 64'h7FFF_FFFF_FFFF_FFFF);

      // Broken alphabets: bases out of range, sign characters, a repeat.
      configure(HEX_LOW, HEX_HIGH, 5'd0);
      send_item(1'b1, 64'd12345);
      configure(HEX_LOW, HEX_HIGH, 5'd1);
      send_item(1'b0, 64'hFFFF_FFFF_FFFF_FFF0);
      configure(HEX_LOW, HEX_HIGH, 5'd17);
      send_item(1'b1, 64'd7);
      configure(HEX_LOW, HEX_HIGH, 5'd31);
      send_item(1'b0, 64'd7);
      configure(64'h3736_3534_2D32_3130, HEX_HIGH, 5'd10);
      send_item(1'b1, 64'd99);
      configure(HEX_LOW, 64'h4645_4443_4241_2B38, 5'd16);
      send_item(1'b1, 64'd99);
      configure(HEX_LOW, 64'h3045_4443_4241_3938, 5'd16);
      send_item(1'b0, 64'd99);

      // A minus character just past the base is allowed.
      configure(64'h3736_3534_3332_3130, 64'h4645_4443_4241_2D38, 5'd9);
      send_item(1'b1, 64'hFFFF_FFFF_FFFF_FF00);

      // Random phases: a fresh alphabet each, every fourth one broken.
      for (int phase = 0; phase < 12; phase++) begin
         flaw = (phase % 4 == 3) ? alphabet_flaw_type'($urandom_range(1, 4)) : FLAW_NONE;
         random_alphabet(flaw, (phase == 0) ? 2 : (phase == 1) ? MAX_RADIX : 0, lo, hi, rad);
         configure(lo, hi, rad);
         no_gaps = (phase % 3 == 2);
         for (int n = 0; n < 30; n++) begin
            send_item(1'($urandom_range(0, 1)), pick_value());
            if (!no_gaps) begin
               idle_gap();
            end
         end
      end

      // Drain, then leave room for any stray beat.
      wait_for_idle();
      repeat (700) @(posedge clock);
      sb.report_leftovers();
      if (sb.error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== radix_digit_emitter_core.f =====
design/rde_pkg.sv
design/rde_div_step.sv
design/rde_digit_ram.sv
design/radix_digit_emitter_core.sv
design/rde_checker.sv
bench/tb_radix_digit_emitter_core.sv
